/* hw/rtl/ffha_pkg.sv */
package ffha_pkg;

  // default configuration of the block
  localparam int unsigned DefMaxBlocks   = 64;
  localparam int unsigned DefAddrBits    = 22;
  localparam int unsigned DefHeaderBytes = 8;

  // trailing slack behind every block payload
  localparam int unsigned LinkBytes = 4;

  // reset value of the heap limit register
  localparam int unsigned HeapLimitReset = 4063232;

  // command codes carried in tuser
  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  // result status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StZero    = 2'd1;
  localparam logic [1:0] StOom     = 2'd2;
  localparam logic [1:0] StUnknown = 2'd3;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgHeapBase  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHeapLimit = 1'b1;

  // outcome of one table entry compare
  typedef struct packed {
    logic fits;   // free block large enough for the request
    logic owns;   // taken block whose data address matches
  } ffha_match_t;

endpackage

/* hw/rtl/ffha_ram.sv */
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/ffha_match.sv */
module ffha_match
  import ffha_pkg::*;
#(
  parameter int unsigned ADDR_BITS    = DefAddrBits,
  parameter int unsigned HEADER_BYTES = DefHeaderBytes
) (
  input  logic [ADDR_BITS-1:0] start_i,
  input  logic [ADDR_BITS-1:0] length_i,
  input  logic                 taken_i,
  input  logic [ADDR_BITS-1:0] size_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  output ffha_match_t          match_o
);

  logic [ADDR_BITS-1:0] data_addr;

  // data address of the entry, wrapping at the address width
  assign data_addr = start_i + ADDR_BITS'(HEADER_BYTES);

  // first-fit test and free lookup test share the entry read
  assign match_o.fits = !taken_i && (length_i >= size_i);
  assign match_o.owns = taken_i && (data_addr == addr_i);

endmodule

/* hw/rtl/first_fit_heap_allocator_core.sv */
// First-fit heap allocator. Each item on the slave stream is an allocate or a
// free command; exactly one result item follows it on the master stream. The
// block table (header address and length per block) sits in a RAM with one
// write port and one registered read port that is walked one entry per cycle.
// An allocate or free walks the table up to block_count entries (at most
// MAX_BLOCKS); a zero-size allocate skips the walk. The slave side is
// ready only while no command is in progress. A finished result waits in the
// output register without blocking the next command, but that command cannot
// finish, and so holds off the slave side, until the waiting result is taken.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i;
// writing heap_base also moves the top pointer while idle with an empty table.
module first_fit_heap_allocator_core
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS   = DefMaxBlocks,
  parameter int unsigned ADDR_BITS    = DefAddrBits,
  parameter int unsigned HEADER_BYTES = DefHeaderBytes,
  localparam int unsigned InW  = ((2 * ADDR_BITS + 7) / 8) * 8,
  localparam int unsigned OutW = ((2 * ADDR_BITS + 2 + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ADDR_BITS-1:0] cfg_data_i,
  // command stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InW-1:0]       s_axis_tdata,  // request_size, free_address, zero pad
  input  logic                 s_axis_tuser,  // command
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutW-1:0]      m_axis_tdata   // data_address, status, bytes_in_use, zero pad
);

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned WideW = ADDR_BITS + 2;

  // sequencer states
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0] state_q, state_d;

  logic [ADDR_BITS-1:0] base_q, limit_q;
  logic [ADDR_BITS-1:0] top_q, top_d;
  logic [ADDR_BITS-1:0] used_q, used_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [MAX_BLOCKS-1:0] taken_q, taken_d;

  logic                 cmd_q;
  logic [ADDR_BITS-1:0] size_q, faddr_q;

  logic [CntW-1:0] scan_q, scan_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic            cmp_vld_q, cmp_vld_d;

  logic [ADDR_BITS-1:0] res_addr_q, res_addr_d;
  logic [1:0]           res_st_q, res_st_d;

  logic                 out_vld_q;
  logic [ADDR_BITS-1:0] out_addr_q, out_used_q;
  logic [1:0]           out_st_q;

  logic                     ram_we;
  logic [IdxW-1:0]          ram_waddr;
  logic [2*ADDR_BITS-1:0]   ram_wdata, ram_rdata;
  logic [ADDR_BITS-1:0]     ent_start, ent_len;
  ffha_match_t              match;
  logic                     hit;
  logic                     in_acc, out_free;
  logic [WideW-1:0]         need_end;
  logic                     oom;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle);

  // block table: header address in the low half, length in the high half
  ffha_ram #(
    .WIDTH (2 * ADDR_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ent_start = ram_rdata[ADDR_BITS-1:0];
  assign ent_len   = ram_rdata[2*ADDR_BITS-1:ADDR_BITS];

  // shared entry compare
  ffha_match #(
    .ADDR_BITS    (ADDR_BITS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_match (
    .start_i  (ent_start),
    .length_i (ent_len),
    .taken_i  (taken_q[cmp_idx_q]),
    .size_i   (size_q),
    .addr_i   (faddr_q),
    .match_o  (match)
  );

  assign hit = cmp_vld_q && ((cmd_q == CmdAlloc) ? match.fits : match.owns);

  // end of a new block, compared without wrap
  assign need_end = WideW'(top_q) + WideW'(size_q) + WideW'(HEADER_BYTES);
  assign oom = (cnt_q >= CntW'(MAX_BLOCKS)) || (need_end >= WideW'(limit_q));

  assign ram_waddr = cnt_q[IdxW-1:0];
  assign ram_wdata = {size_q, top_q};

  // sequencer
  always_comb begin
    state_d    = state_q;
    top_d      = top_q;
    used_d     = used_q;
    cnt_d      = cnt_q;
    taken_d    = taken_q;
    scan_d     = scan_q;
    cmp_idx_d  = cmp_idx_q;
    cmp_vld_d  = cmp_vld_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    ram_we     = 1'b0;
    case (state_q)
      StIdle: begin
        scan_d    = '0;
        cmp_vld_d = 1'b0;
        if (cfg_we_i && (cfg_idx_i == CfgHeapBase) && (cnt_q == '0)) begin
          top_d = cfg_data_i;
        end
        if (in_acc) begin
          if ((s_axis_tuser == CmdAlloc) && (s_axis_tdata[ADDR_BITS-1:0] == '0)) begin
            res_addr_d = '0;
            res_st_d   = StZero;
            state_d    = StFinish;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (hit) begin
          // first match ends the walk
          taken_d[cmp_idx_q] = (cmd_q == CmdAlloc);
          if (cmd_q == CmdAlloc) begin
            used_d     = used_q + size_q + ADDR_BITS'(HEADER_BYTES);
            res_addr_d = ent_start + ADDR_BITS'(HEADER_BYTES);
          end else begin
            used_d     = used_q - ent_len - ADDR_BITS'(HEADER_BYTES);
            res_addr_d = '0;
          end
          res_st_d = StOk;
          state_d  = StFinish;
        end else if (scan_q < cnt_q) begin
          // issue the next entry read
          cmp_idx_d = scan_q[IdxW-1:0];
          cmp_vld_d = 1'b1;
          scan_d    = scan_q + CntW'(1);
        end else begin
          // table exhausted
          cmp_vld_d  = 1'b0;
          res_addr_d = '0;
          state_d    = StFinish;
          if (cmd_q == CmdFree) begin
            res_st_d = StUnknown;
          end else if (oom) begin
            res_st_d = StOom;
          end else begin
            ram_we     = 1'b1;
            taken_d[cnt_q[IdxW-1:0]] = 1'b1;
            cnt_d      = cnt_q + CntW'(1);
            top_d      = top_q + size_q + ADDR_BITS'(HEADER_BYTES + LinkBytes);
            used_d     = used_q + size_q + ADDR_BITS'(HEADER_BYTES + LinkBytes);
            res_addr_d = top_q + ADDR_BITS'(HEADER_BYTES);
            res_st_d   = StOk;
          end
        end
      end
      StFinish: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      base_q    <= '0;
      limit_q   <= ADDR_BITS'(HeapLimitReset);
      top_q     <= '0;
      used_q    <= '0;
      cnt_q     <= '0;
      taken_q   <= '0;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      top_q     <= top_d;
      used_q    <= used_d;
      cnt_q     <= cnt_d;
      taken_q   <= taken_d;
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
      if (cfg_we_i && (cfg_idx_i == CfgHeapBase)) begin
        base_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == CfgHeapLimit)) begin
        limit_q <= cfg_data_i;
      end
      if ((state_q == StFinish) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    if (in_acc) begin
      cmd_q   <= s_axis_tuser;
      size_q  <= s_axis_tdata[ADDR_BITS-1:0];
      faddr_q <= s_axis_tdata[2*ADDR_BITS-1:ADDR_BITS];
    end
    if ((state_q == StFinish) && out_free) begin
      out_addr_q <= res_addr_q;
      out_st_q   <= res_st_q;
      out_used_q <= used_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutW'({out_used_q, out_st_q, out_addr_q});

  // block count only grows, and by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("block count moved by more than one");

  // table never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_BLOCKS))
    else $error("block count beyond table depth");

  // no used mark above the filled part of the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (taken_q >> cnt_q) == '0)
    else $error("used mark on an unfilled entry");

  // a new command starts its walk with no entry in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !cmp_vld_q)
    else $error("stale entry compare at start of walk");

  // a heap base write on an idle, empty table moves the top pointer to it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && cnt_q == '0 && !in_acc && $past(cfg_we_i)
     && $past(cfg_idx_i == CfgHeapBase) && $past(state_q == StIdle)
     && $past(cnt_q == '0)) |-> (top_q == base_q))
    else $error("top pointer not moved with heap base");

endmodule
